[rtl/core/delta_rle_id_list_encoder_macros.svh]
// assertion macros used by drle_drain, one of the delta run-length encoder modules
// no dependencies; pulled in by files that carry concurrent checks
`ifndef DELTA_RLE_ID_LIST_ENCODER_MACROS_SVH
`define DELTA_RLE_ID_LIST_ENCODER_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define DRLE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define DRLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/drle_pkg.sv]
// shared types and constants for the delta run-length id list encoder
// no dependencies
package drle_pkg;

  localparam int OP_BITS   = 2;
  localparam int IN_BITS   = 31;
  localparam int CODE_BITS = 32;
  localparam int MAX_WORDS = 4;
  localparam int CNT_BITS  = 3;
  localparam int IDX_BITS  = 2;

  localparam logic [OP_BITS-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_BITS-1:0] OP_RUN   = 2'd1;
  localparam logic [OP_BITS-1:0] OP_FLUSH = 2'd2;

  typedef logic [CODE_BITS-1:0] code_t;

  typedef struct packed {
    code_t code;
    logic  is_end;
    logic  last;
  } word_t;

  // all words caused by one item, word 0 goes out first
  typedef struct packed {
    logic [CNT_BITS-1:0]        cnt;
    word_t [MAX_WORDS-1:0]      w;
  } group_t;

endpackage

[rtl/core/drle_prep.sv]
// input register and run product stage of the encoder
// depends on drle_pkg
module drle_prep #(
  parameter int ID_BITS    = 31,
  parameter int COUNT_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [drle_pkg::OP_BITS-1:0] operation,
  input  logic [drle_pkg::IN_BITS-1:0] item_id,
  input  logic [drle_pkg::IN_BITS-1:0] run_step,
  input  logic [drle_pkg::IN_BITS-1:0] run_extra,
  output logic                         p_valid,
  input  logic                         p_ready,
  output logic [drle_pkg::OP_BITS-1:0] p_op,
  output logic [ID_BITS-1:0]           p_id,
  output logic [ID_BITS-1:0]           p_step,
  output logic [ID_BITS-1:0]           p_prod,
  output logic [COUNT_BITS-1:0]        p_extra,
  output logic [COUNT_BITS-1:0]        p_extra_p1,
  output logic                         p_extra_nz
);
  import drle_pkg::*;

  logic               v0;
  logic [OP_BITS-1:0] op0;
  logic [ID_BITS-1:0] id0;
  logic [ID_BITS-1:0] step0;
  logic [IN_BITS-1:0] extra0;
  logic               ld1;
  logic [ID_BITS-1:0] prod;

  assign ld1      = v0 && (!p_valid || p_ready);
  // no beat is taken while reset is held
  assign in_ready = !rst && (!v0 || ld1);

  // only the low id bits of step * extra matter, so extra is cut to id width
  assign prod = step0 * extra0[ID_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v0      <= 1'b0;
      p_valid <= 1'b0;
    end else begin
      if (in_ready) v0 <= in_valid;
      if (ld1) p_valid <= 1'b1;
      else if (p_ready) p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op0    <= operation;
      id0    <= ID_BITS'(item_id);
      step0  <= ID_BITS'(run_step);
      extra0 <= run_extra;
    end
    if (ld1) begin
      p_op       <= op0;
      p_id       <= id0;
      p_step     <= step0;
      p_prod     <= prod;
      p_extra    <= COUNT_BITS'(extra0);
      p_extra_p1 <= COUNT_BITS'(extra0) + COUNT_BITS'(1);
      p_extra_nz <= |extra0;
    end
  end

endmodule

[rtl/core/drle_core.sv]
// encoder state and word generation: one item per cycle into a word group while the drain can load one
// depends on drle_pkg
module drle_core #(
  parameter int ID_BITS    = 31,
  parameter int COUNT_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         p_valid,
  output logic                         p_ready,
  input  logic [drle_pkg::OP_BITS-1:0] p_op,
  input  logic [ID_BITS-1:0]           p_id,
  input  logic [ID_BITS-1:0]           p_step,
  input  logic [ID_BITS-1:0]           p_prod,
  input  logic [COUNT_BITS-1:0]        p_extra,
  input  logic [COUNT_BITS-1:0]        p_extra_p1,
  input  logic                         p_extra_nz,
  output drle_pkg::group_t             grp,
  output logic                         grp_load,
  input  logic                         grp_can_load
);
  import drle_pkg::*;

  logic [ID_BITS-1:0]    prev_id, prev_id_next;
  logic [ID_BITS-1:0]    last_diff, last_diff_next;
  logic [COUNT_BITS-1:0] run_len, run_len_next;
  logic [COUNT_BITS-1:0] elem_count, elem_count_next;

  logic [ID_BITS-1:0]    diff1, ld1;
  logic [COUNT_BITS-1:0] run1;
  logic                  same1, same2, is_push, is_run, is_flush, en_a, en_b, two_push;
  word_t                 c [MAX_WORDS];
  logic [MAX_WORDS-1:0]  en;
  word_t [MAX_WORDS-1:0] w;
  logic [CNT_BITS-1:0]   k;
  logic [IDX_BITS-1:0]   li;

  function automatic code_t diff_word(input logic [ID_BITS-1:0] d);
    return CODE_BITS'({d, 1'b0});
  endfunction

  function automatic code_t run_word(input logic [COUNT_BITS-1:0] r);
    return CODE_BITS'({r, 1'b1});
  endfunction

  assign p_ready  = grp_can_load;
  assign grp_load = p_valid && grp_can_load;

  assign is_run   = (p_op == OP_RUN);
  assign is_push  = (p_op == OP_PUSH) || is_run;
  assign is_flush = (p_op == OP_FLUSH);
  assign two_push = is_run && p_extra_nz;

  // first push against the stored state
  assign diff1 = p_id - prev_id;
  assign same1 = (diff1 == last_diff);
  assign run1  = same1 ? run_len + COUNT_BITS'(1) : COUNT_BITS'(1);
  assign ld1   = same1 ? last_diff : diff1;
  // second push of a run has difference step
  assign same2 = (p_step == ld1);

  assign en_a = is_flush || (is_push && !same1);
  assign en_b = two_push && !same2;

  always_comb begin
    c[0] = '{code: (run_len == COUNT_BITS'(1)) ? diff_word(last_diff) : run_word(run_len),
             is_end: 1'b0, last: 1'b0};
    c[1] = '{code: diff_word(last_diff), is_end: 1'b0, last: 1'b0};
    en[0] = en_a && (run_len != '0);
    en[1] = en_a && (run_len != '0) && (run_len != COUNT_BITS'(1));
    if (is_flush) begin
      c[2]  = '{code: CODE_BITS'(elem_count), is_end: 1'b1, last: 1'b0};
      c[3]  = '{code: '0, is_end: 1'b0, last: 1'b0};
      en[2] = 1'b1;
      en[3] = 1'b0;
    end else begin
      c[2]  = '{code: (run1 == COUNT_BITS'(1)) ? diff_word(ld1) : run_word(run1),
                is_end: 1'b0, last: 1'b0};
      c[3]  = '{code: diff_word(ld1), is_end: 1'b0, last: 1'b0};
      en[2] = en_b && (run1 != '0);
      en[3] = en_b && (run1 != '0) && (run1 != COUNT_BITS'(1));
    end
  end

  // pack the enabled words to the front and tag the final one
  always_comb begin
    w = '0;
    k = '0;
    for (int i = 0; i < MAX_WORDS; i++) begin
      if (en[i]) begin
        w[k[IDX_BITS-1:0]] = c[i];
        k = k + CNT_BITS'(1);
      end
    end
    li = k[IDX_BITS-1:0] - IDX_BITS'(1);
    if (k != '0) w[li].last = 1'b1;
    grp.cnt = k;
    grp.w   = w;
  end

  always_comb begin
    prev_id_next    = prev_id;
    last_diff_next  = last_diff;
    run_len_next    = run_len;
    elem_count_next = elem_count;
    if (is_flush) begin
      run_len_next = '0;
    end else if (two_push) begin
      // id + step * extra is where the run ends
      prev_id_next    = p_id + p_prod;
      last_diff_next  = same2 ? ld1 : p_step;
      run_len_next    = (same2 ? run1 : '0) + p_extra;
      elem_count_next = elem_count + p_extra_p1;
    end else if (is_push) begin
      prev_id_next    = p_id;
      last_diff_next  = ld1;
      run_len_next    = run1;
      elem_count_next = elem_count + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_id    <= '0;
      last_diff  <= '0;
      run_len    <= '0;
      elem_count <= '0;
    end else if (grp_load) begin
      prev_id    <= prev_id_next;
      last_diff  <= last_diff_next;
      run_len    <= run_len_next;
      elem_count <= elem_count_next;
    end
  end

endmodule

[rtl/core/drle_drain.sv]
// word group buffer and output register, one beat per cycle while the receiver does not stall
// depends on drle_pkg and delta_rle_id_list_encoder_macros.svh
`include "delta_rle_id_list_encoder_macros.svh"

module drle_drain (
  input  logic                clk,
  input  logic                rst,
  input  drle_pkg::group_t    grp,
  input  logic                grp_load,
  output logic                grp_can_load,
  output logic                out_valid,
  input  logic                out_ready,
  output drle_pkg::code_t     code,
  output logic                is_end,
  output logic                last
);
  import drle_pkg::*;

  group_t grp_q;
  logic   take;
  logic   take_last;
  logic   take_more;
  logic   one_left;

  assign take         = (grp_q.cnt != '0) && (!out_valid || out_ready);
  assign grp_can_load = (grp_q.cnt == '0) || ((grp_q.cnt == CNT_BITS'(1)) && take);

  assign take_last = take && grp_q.w[0].last;
  assign take_more = take && !grp_q.w[0].last;
  assign one_left  = (grp_q.cnt == CNT_BITS'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      grp_q.cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (grp_load) grp_q.cnt <= grp.cnt;
      else if (take) grp_q.cnt <= grp_q.cnt - CNT_BITS'(1);
      if (take) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
    if (grp_load) begin
      grp_q.w <= grp.w;
    end else if (take) begin
      for (int i = 0; i < MAX_WORDS - 1; i++) grp_q.w[i] <= grp_q.w[i+1];
    end
    if (take) begin
      code   <= grp_q.w[0].code;
      is_end <= grp_q.w[0].is_end;
      last   <= grp_q.w[0].last;
    end
  end

  `DRLE_ASSERT_SAME(a_last_ends_group, clk, rst, take_last, one_left, "last beat with words left")
  `DRLE_ASSERT_NEXT(a_group_continues, clk, rst, take_more, grp_q.cnt != '0, "emptied early")
  `DRLE_ASSERT_SAME(a_end_is_last, clk, rst, out_valid && is_end, last, "end beat without last")

endmodule

[rtl/core/delta_rle_id_list_encoder.sv]
// Delta run-length encoder for ascending id lists.
// Input channel in_valid/in_ready carries operation, item_id, run_step,
// run_extra; output channel out_valid/out_ready carries code, is_end, last.
// Operation push adds one id, run adds an arithmetic run of 1 + run_extra
// ids, flush emits the pending run and an end word with the element count.
// An item makes zero to four output beats; last marks the final beat of
// an item.
// The first beat of an item passes the input register, the product
// register, the word group and the output register in that order.
// Throughput: one item per cycle while items make at most one beat and
// the receiver does not stall; an item making more beats holds the
// word group buffer until all of them are out through the single output
// register, which sets the rate for such items.
// Reset clears the stored previous id, difference, run length and count
// and empties every stage; in_ready is low while reset is held. When the
// receiver stalls the output register holds its beat, the word group
// fills, and in_ready drops once the input and product registers are also
// full; nothing is lost.
// depends on drle_pkg, drle_prep, drle_core, drle_drain
module delta_rle_id_list_encoder #(
  parameter int ID_BITS    = 31,
  parameter int COUNT_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [drle_pkg::OP_BITS-1:0]   operation,
  input  logic [drle_pkg::IN_BITS-1:0]   item_id,
  input  logic [drle_pkg::IN_BITS-1:0]   run_step,
  input  logic [drle_pkg::IN_BITS-1:0]   run_extra,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [drle_pkg::CODE_BITS-1:0] code,
  output logic                           is_end,
  output logic                           last
);
  import drle_pkg::*;

  logic                  p_valid, p_ready, p_extra_nz;
  logic [OP_BITS-1:0]    p_op;
  logic [ID_BITS-1:0]    p_id, p_step, p_prod;
  logic [COUNT_BITS-1:0] p_extra, p_extra_p1;
  group_t                grp;
  logic                  grp_load, grp_can_load;

  drle_prep #(.ID_BITS(ID_BITS), .COUNT_BITS(COUNT_BITS)) u_prep (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .item_id    (item_id),
    .run_step   (run_step),
    .run_extra  (run_extra),
    .p_valid    (p_valid),
    .p_ready    (p_ready),
    .p_op       (p_op),
    .p_id       (p_id),
    .p_step     (p_step),
    .p_prod     (p_prod),
    .p_extra    (p_extra),
    .p_extra_p1 (p_extra_p1),
    .p_extra_nz (p_extra_nz)
  );

  drle_core #(.ID_BITS(ID_BITS), .COUNT_BITS(COUNT_BITS)) u_core (
    .clk          (clk),
    .rst          (rst),
    .p_valid      (p_valid),
    .p_ready      (p_ready),
    .p_op         (p_op),
    .p_id         (p_id),
    .p_step       (p_step),
    .p_prod       (p_prod),
    .p_extra      (p_extra),
    .p_extra_p1   (p_extra_p1),
    .p_extra_nz   (p_extra_nz),
    .grp          (grp),
    .grp_load     (grp_load),
    .grp_can_load (grp_can_load)
  );

  drle_drain u_drain (
    .clk          (clk),
    .rst          (rst),
    .grp          (grp),
    .grp_load     (grp_load),
    .grp_can_load (grp_can_load),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .code         (code),
    .is_end       (is_end),
    .last         (last)
  );

endmodule

[sim/delta_rle_id_list_encoder_tb.sv]
// self-checking testbench for the delta run-length id list encoder
// depends on drle_pkg and delta_rle_id_list_encoder; predicts every output beat
`timescale 1ns / 1ps

module delta_rle_id_list_encoder_tb;
  import drle_pkg::*;

  localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
  localparam logic [30:0] ID_MAX = 31'h7fffffff;
  localparam int RESET_CYCLES = 11;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 20;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_ITEMS = 110;

  typedef struct packed {
    logic [OP_BITS-1:0] op;
    logic [30:0]        id;
    logic [30:0]        step;
    logic [30:0]        extra;
  } enc_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OP_BITS-1:0] operation = '0;
  logic [IN_BITS-1:0] item_id = '0;
  logic [IN_BITS-1:0] run_step = '0;
  logic [IN_BITS-1:0] run_extra = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [CODE_BITS-1:0] code;
  logic is_end;
  logic last;

  delta_rle_id_list_encoder dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .item_id(item_id), .run_step(run_step), .run_extra(run_extra),
    .out_valid(out_valid), .out_ready(out_ready),
    .code(code), .is_end(is_end), .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // encoder state as the block should hold it
  logic [30:0] enc_prev_id = '0;
  logic [30:0] enc_diff = '0;
  logic [31:0] enc_run = '0;
  logic [31:0] enc_count = '0;

  enc_item_t pending_items[$];
  word_t     expected_words[$];
  word_t     item_words[$];
  enc_item_t next_item;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;
  bit in_taken = 1'b0;
  int cycles = 0;
  int items_queued = 0;
  int items_taken = 0;
  int words_checked = 0;
  int ends_checked = 0;
  int mismatches = 0;
  int op_seen[4] = '{0, 0, 0, 0};
  logic [30:0] gen_id = '0;

  // ---------------- predictor ----------------

  task automatic emit_word(input logic [31:0] value, input logic end_flag);
    word_t w;
    w.code = value;
    w.is_end = end_flag;
    w.last = 1'b0;
    item_words.insert(item_words.size(), w);
  endtask

  task automatic close_run();
    if (enc_run == 1) begin
      emit_word({enc_diff, 1'b0}, 1'b0);
    end else if (enc_run != 0) begin
      emit_word({enc_run[30:0], 1'b1}, 1'b0);
      emit_word({enc_diff, 1'b0}, 1'b0);
    end
    enc_run = '0;
  endtask

  task automatic add_id(input logic [30:0] id);
    logic [30:0] d;
    d = id - enc_prev_id;
    if (d == enc_diff) begin
      enc_run = enc_run + 1;
    end else begin
      close_run();
      enc_run = 32'd1;
      enc_diff = d;
    end
    enc_prev_id = id;
    enc_count = enc_count + 1;
  endtask

  task automatic encode_item(input enc_item_t it);
    logic [30:0] rest;
    logic [30:0] span;
    word_t w;
    item_words.delete();
    case (it.op)
      OP_PUSH: begin
        add_id(it.id);
      end
      OP_RUN: begin
        add_id(it.id);
        if (it.extra != 0) begin
          rest = it.extra - 31'd1;
          add_id(it.id + it.step);
          span = it.step * rest;
          enc_run = enc_run + {1'b0, rest};
          enc_prev_id = enc_prev_id + span;
          enc_count = enc_count + {1'b0, rest};
        end
      end
      OP_FLUSH: begin
        close_run();
        emit_word(enc_count, 1'b1);
      end
      default: ;
    endcase
    for (int i = 0; i < item_words.size(); i++) begin
      w = item_words[i];
      w.last = (i == item_words.size() - 1);
      expected_words.insert(expected_words.size(), w);
    end
  endtask

  // ---------------- driver and monitor ----------------

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_item = pending_items.pop_front();
        in_valid <= 1'b1;
        operation <= next_item.op;
        item_id <= next_item.id;
        run_step <= next_item.step;
        run_extra <= next_item.extra;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_seen != hold_seq) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s at beat %0d (cycle %0d): got %h, expected %h",
             what, words_checked, cycles, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    word_t w;
    enc_item_t it;
    in_taken = in_valid && in_ready && !rst;
    if (in_taken) begin
      it.op = operation;
      it.id = item_id;
      it.step = run_step;
      it.extra = run_extra;
      encode_item(it);
      op_seen[operation]++;
      items_taken++;
    end
    if (!rst && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected beat, code", code, '0);
      end else begin
        w = expected_words.pop_front();
        if (code !== w.code) report_mismatch("code", code, w.code);
        if (is_end !== w.is_end) report_mismatch("is_end", is_end, w.is_end);
        if (last !== w.last) report_mismatch("last", last, w.last);
        if (w.is_end) ends_checked++;
      end
      words_checked++;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout: %0d items taken, %0d words still expected",
               items_taken, expected_words.size());
      $display("[delta_rle_id_list_encoder] ERROR");
      $finish;
    end
  end

  // ---------------- stimulus ----------------

  function automatic logic [30:0] rnd31();
    return 31'($urandom);
  endfunction

  task automatic add_item(input logic [OP_BITS-1:0] op, input logic [30:0] id,
                          input logic [30:0] step, input logic [30:0] extra);
    enc_item_t it;
    it.op = op;
    it.id = id;
    it.step = step;
    it.extra = extra;
    pending_items.insert(pending_items.size(), it);
    items_queued++;
  endtask

  task automatic wait_drained();
    while (items_taken != items_queued || expected_words.size() != 0) @(negedge clk);
  endtask

  function automatic logic [30:0] pick_diff(input logic [30:0] a, input logic [30:0] b);
    return ($urandom_range(2) == 0) ? b : a;
  endfunction

  // mostly ascending id streams with recurring differences so that runs build up
  task automatic random_phase(input int n);
    int made;
    int r;
    int seg_len;
    logic [30:0] da;
    logic [30:0] db;
    logic [30:0] d;
    logic [30:0] st;
    logic [30:0] ex;
    made = 0;
    while (made < n) begin
      r = $urandom_range(99);
      if (r < 5) begin
        add_item(OP_UNUSED, rnd31(), rnd31(), rnd31());
      end else if (r < 10) begin
        gen_id = rnd31();
        add_item(OP_PUSH, gen_id, rnd31(), rnd31());
        made++;
      end else if (r < 15) begin
        add_item(OP_FLUSH, rnd31(), rnd31(), rnd31());
        made++;
      end else if (r < 20) begin
        gen_id = rnd31();
        add_item(OP_RUN, gen_id, rnd31(), rnd31());
        made++;
      end else begin
        seg_len = $urandom_range(2, 8);
        da = ($urandom_range(9) == 0) ? rnd31() : 31'($urandom_range(1, 6));
        db = ($urandom_range(3) == 0) ? 31'd0 : 31'($urandom_range(1, 6));
        for (int i = 0; i < seg_len; i++) begin
          d = pick_diff(da, db);
          if ($urandom_range(3) == 0) begin
            st = pick_diff(da, db);
            ex = ($urandom_range(19) == 0) ? rnd31() : 31'($urandom_range(0, 4));
            add_item(OP_RUN, gen_id + d, st, ex);
            gen_id = gen_id + d + st * ex;
          end else begin
            gen_id = gen_id + d;
            add_item(OP_PUSH, gen_id, rnd31(), rnd31());
          end
          made++;
        end
        if ($urandom_range(1) == 0) begin
          add_item(OP_FLUSH, rnd31(), rnd31(), rnd31());
          made++;
        end
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed: first id zero, repeats, wrap, zero step, huge runs, flushes
    add_item(OP_PUSH, 31'd0, rnd31(), rnd31());
    add_item(OP_PUSH, 31'd0, rnd31(), rnd31());
    add_item(OP_PUSH, 31'd5, rnd31(), rnd31());
    add_item(OP_PUSH, 31'd10, rnd31(), rnd31());
    add_item(OP_PUSH, 31'd12, rnd31(), rnd31());
    add_item(OP_UNUSED, ID_MAX, ID_MAX, ID_MAX);
    add_item(OP_PUSH, 31'd3, rnd31(), rnd31());
    add_item(OP_PUSH, ID_MAX, rnd31(), rnd31());
    add_item(OP_RUN, 31'd100, 31'd0, 31'd3);
    add_item(OP_RUN, 31'd200, 31'd7, 31'd0);
    add_item(OP_FLUSH, rnd31(), rnd31(), rnd31());
    add_item(OP_FLUSH, rnd31(), rnd31(), rnd31());
    add_item(OP_PUSH, 31'd210, rnd31(), rnd31());
    add_item(OP_RUN, 31'd220, 31'd10, 31'd1);
    // three maximal runs with the same step: run length and count both wrap
    add_item(OP_RUN, 31'd240, 31'd10, ID_MAX);
    add_item(OP_RUN, 31'd240, 31'd10, ID_MAX);
    add_item(OP_RUN, 31'd240, 31'd10, ID_MAX);
    add_item(OP_FLUSH, '0, '0, '0);
    add_item(OP_RUN, 31'd5, 31'd2, 31'd2);
    add_item(OP_RUN, 31'd20, 31'd3, 31'd1);
    add_item(OP_PUSH, ID_MAX, '0, '0);
    add_item(OP_RUN, 31'd0, ID_MAX, ID_MAX);
    add_item(OP_FLUSH, ID_MAX, ID_MAX, ID_MAX);
    wait_drained();

    // no idling, with a long receiver hold-off so the block backs up
    hold_seq++;
    gen_id = '0;
    random_phase(PHASE_ITEMS);
    wait_drained();

    send_idle_pct = 67;
    recv_stall_pct = 0;
    random_phase(PHASE_ITEMS);
    wait_drained();

    send_idle_pct = 0;
    recv_stall_pct = 67;
    random_phase(PHASE_ITEMS);
    wait_drained();

    send_idle_pct = 14;
    recv_stall_pct = 14;
    random_phase(PHASE_ITEMS);
    add_item(OP_FLUSH, rnd31(), rnd31(), rnd31());
    wait_drained();

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("items taken: %0d push, %0d run, %0d flush, %0d unused code",
             op_seen[OP_PUSH], op_seen[OP_RUN], op_seen[OP_FLUSH], op_seen[OP_UNUSED]);
    $display("output beats checked: %0d (%0d end markers), mismatches: %0d",
             words_checked, ends_checked, mismatches);
    if (mismatches == 0) begin
      $display("[delta_rle_id_list_encoder] OK");
    end else begin
      $display("[delta_rle_id_list_encoder] ERROR");
    end
    $finish;
  end

endmodule
